// ===== hdl/greedy_word_wrap_defines.svh =====
// ----------------------------------------------------------------------------
// Greedy word wrap assertion macros
// Assertion helpers for the checks in the top-level word wrapper file.
// ----------------------------------------------------------------------------
`ifndef GREEDY_WORD_WRAP_DEFINES_SVH
`define GREEDY_WORD_WRAP_DEFINES_SVH

// The consequent holds in the same cycle as the antecedent.
`define GWW_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define GWW_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/gww_pkg.sv =====
// ----------------------------------------------------------------------------
// Greedy word wrap package
// Shared constants, command and status types for the word wrapper.
// ----------------------------------------------------------------------------
package gww_pkg;

    localparam int BYTE_W      = 8;
    localparam int CFG_W       = 8;
    localparam int LL_W        = 9;
    localparam int MAX_WORD    = 32;
    localparam int IDX_W       = (MAX_WORD > 1) ? $clog2(MAX_WORD) : 1;
    localparam int WC_W        = $clog2(MAX_WORD + 1);
    localparam int RAM_ADDR_W  = IDX_W + 1;
    localparam int RAM_DEPTH   = 1 << RAM_ADDR_W;
    localparam int BANKS       = 2;
    localparam int BUSY_W      = 2;
    localparam int CMD_DEPTH   = 4;

    localparam logic [BYTE_W-1:0] CH_SPACE    = 8'd32;
    localparam logic [BYTE_W-1:0] CH_END      = 8'd0;
    localparam logic [BYTE_W-1:0] CH_NL       = 8'd10;
    localparam logic [CFG_W-1:0]  WIDTH_RESET = 8'd80;

    typedef struct packed {
        logic            is_end;
        logic [WC_W-1:0] wc;
        logic            cut;
        logic            bank;
    } t_cmd;

    typedef struct packed {
        logic idle;
        logic release_bank;
    } t_back_status;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_NL,
        BK_WORD,
        BK_SPACE,
        BK_FINAL
    } t_back_state;

endpackage

// ===== hdl/gww_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module gww_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic                                   i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/gww_cmd_fifo.sv =====
// ----------------------------------------------------------------------------
// Command queue
// Small register queue that carries flush commands from front to back.
// ----------------------------------------------------------------------------
module gww_cmd_fifo #(
    parameter int DEPTH = gww_pkg::CMD_DEPTH
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  gww_pkg::t_cmd i_cmd,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_valid,
    output gww_pkg::t_cmd o_head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    gww_pkg::t_cmd    r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             w_do_push;
    logic             w_do_pop;

    assign o_full    = (r_count == CNT_W'(DEPTH));
    assign o_valid   = (r_count != '0);
    assign o_head    = r_mem[r_rd_ptr];
    assign w_do_push = i_push && !o_full;
    assign w_do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (w_do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            case ({w_do_push, w_do_pop})
                2'b10:   r_count <= r_count + CNT_W'(1);
                2'b01:   r_count <= r_count - CNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ===== hdl/gww_front.sv =====
// ----------------------------------------------------------------------------
// Word wrap front end
// Accepts text bytes, gathers words into the store and issues flush commands.
// ----------------------------------------------------------------------------
module gww_front (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_push,
    output logic                                 o_full,
    input  logic [gww_pkg::BYTE_W-1:0]           i_in_byte,
    input  logic                                 i_release,
    input  logic                                 i_fifo_full,
    output logic                                 o_cmd_push,
    output gww_pkg::t_cmd                        o_cmd,
    output logic                                 o_ram_we,
    output logic [gww_pkg::RAM_ADDR_W-1:0]       o_ram_waddr,
    output logic [gww_pkg::BYTE_W-1:0]           o_ram_wdata,
    output logic [gww_pkg::BUSY_W-1:0]           o_busy
);

    logic [gww_pkg::WC_W-1:0]   r_wc;
    logic [gww_pkg::WC_W-1:0]   n_wc;
    logic                       r_cut;
    logic                       n_cut;
    logic                       r_bank;
    logic                       n_bank;
    logic [gww_pkg::BUSY_W-1:0] r_busy;
    logic [gww_pkg::BUSY_W-1:0] n_busy;
    logic                       w_accept;
    logic                       w_claim;

    assign o_full      = i_fifo_full || (r_busy == gww_pkg::BUSY_W'(gww_pkg::BANKS));
    assign w_accept    = i_push && !o_full;
    assign o_ram_waddr = {r_bank, r_wc[gww_pkg::IDX_W-1:0]};
    assign o_ram_wdata = i_in_byte;
    assign o_busy      = r_busy;

    always_comb begin
        n_wc        = r_wc;
        n_cut       = r_cut;
        n_bank      = r_bank;
        w_claim     = 1'b0;
        o_cmd_push  = 1'b0;
        o_ram_we    = 1'b0;
        o_cmd.is_end = (i_in_byte == gww_pkg::CH_END);
        o_cmd.wc    = r_wc;
        o_cmd.cut   = r_cut;
        o_cmd.bank  = r_bank;
        if (w_accept) begin
            if (i_in_byte == gww_pkg::CH_SPACE || i_in_byte == gww_pkg::CH_END) begin
                o_cmd_push = (r_wc != '0) || (i_in_byte == gww_pkg::CH_END);
                w_claim    = (r_wc != '0);
                n_bank     = r_bank ^ (r_wc != '0);
                n_wc       = '0;
                n_cut      = 1'b0;
            end else if (r_wc < gww_pkg::WC_W'(gww_pkg::MAX_WORD)) begin
                o_ram_we = 1'b1;
                n_wc     = r_wc + gww_pkg::WC_W'(1);
            end else begin
                n_cut = 1'b1;
            end
        end
        n_busy = r_busy + gww_pkg::BUSY_W'(w_claim) - gww_pkg::BUSY_W'(i_release);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wc   <= '0;
            r_cut  <= 1'b0;
            r_bank <= 1'b0;
            r_busy <= '0;
        end else begin
            r_wc   <= n_wc;
            r_cut  <= n_cut;
            r_bank <= n_bank;
            r_busy <= n_busy;
        end
    end

endmodule

// ===== hdl/gww_back.sv =====
// ----------------------------------------------------------------------------
// Word wrap back end
// Executes flush commands: wrap decision, word walk, space and final newline.
// ----------------------------------------------------------------------------
module gww_back (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [gww_pkg::CFG_W-1:0]        i_cfg_wdata,
    input  logic                             i_cmd_valid,
    input  gww_pkg::t_cmd                    i_cmd,
    output logic                             o_cmd_pop,
    output logic                             o_rd_en,
    output logic [gww_pkg::RAM_ADDR_W-1:0]   o_rd_addr,
    input  logic [gww_pkg::BYTE_W-1:0]       i_rd_data,
    output gww_pkg::t_back_status            o_status,
    output logic                             o_empty,
    input  logic                             i_pop,
    output logic [gww_pkg::BYTE_W-1:0]       o_out_byte,
    output logic                             o_run_last,
    output logic                             o_text_done,
    output logic                             o_word_cut
);

    gww_pkg::t_back_state      r_state;
    gww_pkg::t_back_state      n_state;
    gww_pkg::t_cmd             r_cmd;
    gww_pkg::t_cmd             n_cmd;
    logic [gww_pkg::IDX_W-1:0] r_idx;
    logic [gww_pkg::IDX_W-1:0] n_idx;
    logic [gww_pkg::LL_W-1:0]  r_line_len;
    logic [gww_pkg::LL_W-1:0]  n_line_len;
    logic [gww_pkg::CFG_W-1:0] r_width;
    logic                      r_out_valid;
    logic                      n_out_valid;
    logic [gww_pkg::BYTE_W-1:0] r_out_byte;
    logic [gww_pkg::BYTE_W-1:0] n_out_byte;
    logic                      r_run_last;
    logic                      n_run_last;
    logic                      r_done;
    logic                      n_done;
    logic                      r_cut;
    logic                      n_cut;
    logic                      w_can_emit;
    logic                      w_wrap;

    assign w_can_emit = !r_out_valid || i_pop;
    assign w_wrap = ({1'b0, r_line_len} + (gww_pkg::LL_W + 1)'(i_cmd.wc))
                    > (gww_pkg::LL_W + 1)'(r_width);

    assign o_empty     = !r_out_valid;
    assign o_out_byte  = r_out_byte;
    assign o_run_last  = r_run_last;
    assign o_text_done = r_done;
    assign o_word_cut  = r_cut;

    always_comb begin
        n_state     = r_state;
        n_cmd       = r_cmd;
        n_idx       = r_idx;
        n_line_len  = r_line_len;
        n_out_valid = r_out_valid && !i_pop;
        n_out_byte  = r_out_byte;
        n_run_last  = r_run_last;
        n_done      = r_done;
        n_cut       = r_cut;
        o_cmd_pop   = 1'b0;
        o_rd_en     = 1'b0;
        o_rd_addr   = {r_cmd.bank, r_idx + gww_pkg::IDX_W'(1)};
        o_status.idle         = (r_state == gww_pkg::BK_IDLE);
        o_status.release_bank = 1'b0;
        unique case (r_state)
            gww_pkg::BK_IDLE: begin
                if (i_cmd_valid) begin
                    o_cmd_pop = 1'b1;
                    n_cmd     = i_cmd;
                    n_idx     = '0;
                    if (i_cmd.wc != '0) begin
                        o_rd_en   = 1'b1;
                        o_rd_addr = {i_cmd.bank, gww_pkg::IDX_W'(0)};
                        n_state   = w_wrap ? gww_pkg::BK_NL : gww_pkg::BK_WORD;
                    end else begin
                        n_state = gww_pkg::BK_FINAL;
                    end
                end
            end
            gww_pkg::BK_NL: begin
                if (w_can_emit) begin
                    n_out_valid = 1'b1;
                    n_out_byte  = gww_pkg::CH_NL;
                    n_run_last  = 1'b0;
                    n_done      = 1'b0;
                    n_cut       = r_cmd.cut;
                    n_line_len  = '0;
                    n_state     = gww_pkg::BK_WORD;
                end
            end
            gww_pkg::BK_WORD: begin
                if (w_can_emit) begin
                    n_out_valid = 1'b1;
                    n_out_byte  = i_rd_data;
                    n_run_last  = 1'b0;
                    n_done      = 1'b0;
                    n_cut       = r_cmd.cut;
                    o_rd_en     = 1'b1;
                    n_idx       = r_idx + gww_pkg::IDX_W'(1);
                    if (gww_pkg::WC_W'(r_idx) + gww_pkg::WC_W'(1) == r_cmd.wc) begin
                        n_state = gww_pkg::BK_SPACE;
                    end
                end
            end
            gww_pkg::BK_SPACE: begin
                if (w_can_emit) begin
                    n_out_valid = 1'b1;
                    n_out_byte  = gww_pkg::CH_SPACE;
                    n_run_last  = !r_cmd.is_end;
                    n_done      = 1'b0;
                    n_cut       = r_cmd.cut;
                    n_line_len  = r_line_len + gww_pkg::LL_W'(r_cmd.wc) + gww_pkg::LL_W'(1);
                    o_status.release_bank = 1'b1;
                    n_state = r_cmd.is_end ? gww_pkg::BK_FINAL : gww_pkg::BK_IDLE;
                end
            end
            gww_pkg::BK_FINAL: begin
                if (w_can_emit) begin
                    n_out_valid = 1'b1;
                    n_out_byte  = gww_pkg::CH_NL;
                    n_run_last  = 1'b1;
                    n_done      = 1'b1;
                    n_cut       = 1'b0;
                    n_line_len  = '0;
                    n_state     = gww_pkg::BK_IDLE;
                end
            end
            default: begin
                n_state = gww_pkg::BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= gww_pkg::BK_IDLE;
            r_line_len  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_line_len  <= n_line_len;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width <= gww_pkg::WIDTH_RESET;
        end else if (i_cfg_we) begin
            r_width <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd      <= n_cmd;
        r_idx      <= n_idx;
        r_out_byte <= n_out_byte;
        r_run_last <= n_run_last;
        r_done     <= n_done;
        r_cut      <= n_cut;
    end

endmodule

// ===== hdl/greedy_word_wrap.sv =====
// ----------------------------------------------------------------------------
// Greedy word wrap
// Streams text one byte per transaction and emits it wrapped to a line width.
//
// Input side: a queue write port (push, full) carrying one text byte. Space
// separates words and byte zero ends the text. Result side: a queue read port
// (empty, pop); each transaction is one emitted byte with its flags.
// A word byte is taken and produces nothing. A space that ends a word, or an
// end byte, queues a flush command. For a word the back end emits an optional
// newline, the word bytes from the two-bank word store and a space; for the
// end of text it then emits a final newline. The word store read port walks
// one byte per cycle while the receiver keeps popping, and the back end takes
// the next flush command only once it is idle again.
// The front keeps accepting bytes while the back works, until both store
// banks hold words not yet emitted or the command queue is full.
// Write the line width through i_cfg_we / i_cfg_wdata only while the block
// is idle; the block itself does not enforce this. Reset clears the word,
// bank and line counters and the queues and sets the width to 80. When the
// receiver stops popping, the back end holds its result and stalls.
// ----------------------------------------------------------------------------
`include "greedy_word_wrap_defines.svh"

module greedy_word_wrap #(
    parameter int CMD_DEPTH = gww_pkg::CMD_DEPTH
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [gww_pkg::CFG_W-1:0]     i_cfg_wdata,
    input  logic                          push,
    output logic                          full,
    input  logic [gww_pkg::BYTE_W-1:0]    i_in_byte,
    output logic                          empty,
    input  logic                          pop,
    output logic [gww_pkg::BYTE_W-1:0]    o_out_byte,
    output logic                          o_run_last,
    output logic                          o_text_done,
    output logic                          o_word_cut
);

    logic                              w_fifo_full;
    logic                              w_cmd_push;
    gww_pkg::t_cmd                     w_cmd_in;
    logic                              w_cmd_valid;
    gww_pkg::t_cmd                     w_cmd_head;
    logic                              w_cmd_pop;
    logic                              w_ram_we;
    logic [gww_pkg::RAM_ADDR_W-1:0]    w_ram_waddr;
    logic [gww_pkg::BYTE_W-1:0]        w_ram_wdata;
    logic                              w_ram_re;
    logic [gww_pkg::RAM_ADDR_W-1:0]    w_ram_raddr;
    logic [gww_pkg::BYTE_W-1:0]        w_ram_rdata;
    logic [gww_pkg::BUSY_W-1:0]        w_busy;
    gww_pkg::t_back_status             w_back_status;

    gww_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .o_full      (full),
        .i_in_byte   (i_in_byte),
        .i_release   (w_back_status.release_bank),
        .i_fifo_full (w_fifo_full),
        .o_cmd_push  (w_cmd_push),
        .o_cmd       (w_cmd_in),
        .o_ram_we    (w_ram_we),
        .o_ram_waddr (w_ram_waddr),
        .o_ram_wdata (w_ram_wdata),
        .o_busy      (w_busy)
    );

    gww_cmd_fifo #(
        .DEPTH (CMD_DEPTH)
    ) u_cmd_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_cmd_push),
        .i_cmd   (w_cmd_in),
        .o_full  (w_fifo_full),
        .i_pop   (w_cmd_pop),
        .o_valid (w_cmd_valid),
        .o_head  (w_cmd_head)
    );

    gww_ram #(
        .WIDTH (gww_pkg::BYTE_W),
        .DEPTH (gww_pkg::RAM_DEPTH)
    ) u_word_store (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_ram_waddr),
        .i_wdata (w_ram_wdata),
        .i_re    (w_ram_re),
        .i_raddr (w_ram_raddr),
        .o_rdata (w_ram_rdata)
    );

    gww_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_cmd_valid (w_cmd_valid),
        .i_cmd       (w_cmd_head),
        .o_cmd_pop   (w_cmd_pop),
        .o_rd_en     (w_ram_re),
        .o_rd_addr   (w_ram_raddr),
        .i_rd_data   (w_ram_rdata),
        .o_status    (w_back_status),
        .o_empty     (empty),
        .i_pop       (pop),
        .o_out_byte  (o_out_byte),
        .o_run_last  (o_run_last),
        .o_text_done (o_text_done),
        .o_word_cut  (o_word_cut)
    );

    `GWW_ASSERT_SAME(a_drained_no_banks, i_clk, i_rst_n,
                     w_back_status.idle && !w_cmd_valid, w_busy == '0,
                     "Store bank held with no flush pending.")
    `GWW_ASSERT_SAME(a_done_is_final_nl, i_clk, i_rst_n, !empty && o_text_done,
                     (o_out_byte == gww_pkg::CH_NL) && o_run_last && !o_word_cut,
                     "End-of-text result is malformed.")
    `GWW_ASSERT_NEXT(a_release_emits, i_clk, i_rst_n, w_back_status.release_bank,
                     !empty, "Bank released without a result.")

endmodule

// ===== tb/greedy_word_wrap_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Greedy word wrap testbench
// Sends text streams byte by byte through the push side of the wrapper and
// checks every popped byte against a built-in line wrapping predictor. It
// covers directed corner cases first, then random text under several line
// widths, with random sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module greedy_word_wrap_tb;

    localparam int HALF_PERIOD  = 2;
    localparam int RESET_CYCLES = 10;
    localparam int SETTLE_CYCLES = 40;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int STORE_DEPTH  = gww_pkg::MAX_WORD;

    typedef struct {
        logic [gww_pkg::BYTE_W-1:0] ch;
        logic                       last;
        logic                       done;
        logic                       cut;
    } t_wrap_out;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       i_cfg_we = 1'b0;
    logic [gww_pkg::CFG_W-1:0]  i_cfg_wdata = '0;
    logic                       push = 1'b0;
    logic                       full;
    logic [gww_pkg::BYTE_W-1:0] i_in_byte = '0;
    logic                       empty;
    logic                       pop = 1'b0;
    logic [gww_pkg::BYTE_W-1:0] o_out_byte;
    logic                       o_run_last;
    logic                       o_text_done;
    logic                       o_word_cut;

    t_wrap_out                  wrap_out_q[$];
    logic [gww_pkg::BYTE_W-1:0] word_buf[STORE_DEPTH];
    int                         word_fill = 0;
    logic [gww_pkg::LL_W-1:0]   line_pos = '0;
    logic                       word_trunc = 1'b0;
    logic [gww_pkg::CFG_W-1:0]  wrap_width = gww_pkg::WIDTH_RESET;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int mismatch_count = 0;
    int cycle_count = 0;

    greedy_word_wrap dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .push        (push),
        .full        (full),
        .i_in_byte   (i_in_byte),
        .empty       (empty),
        .pop         (pop),
        .o_out_byte  (o_out_byte),
        .o_run_last  (o_run_last),
        .o_text_done (o_text_done),
        .o_word_cut  (o_word_cut)
    );

    always #HALF_PERIOD i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results outstanding.",
                     cycle_count, wrap_out_q.size());
            $display("** greedy_word_wrap: FAILED **");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0t: %s mismatch, got %0d expected %0d", $time, what, got, want);
        mismatch_count++;
    endtask

    // Updates the wrapping state for one accepted byte and queues the bytes it emits.
    task automatic predict_byte(input logic [gww_pkg::BYTE_W-1:0] b);
        t_wrap_out burst[$];
        t_wrap_out r;
        if (b == gww_pkg::CH_SPACE || b == gww_pkg::CH_END) begin
            if (word_fill != 0) begin
                if (int'(line_pos) + word_fill > int'(wrap_width)) begin
                    r = '{gww_pkg::CH_NL, 1'b0, 1'b0, word_trunc};
                    burst.push_back(r);
                    line_pos = '0;
                end
                for (int j = 0; j < word_fill; j++) begin
                    r = '{word_buf[j], 1'b0, 1'b0, word_trunc};
                    burst.push_back(r);
                end
                r = '{gww_pkg::CH_SPACE, 1'b0, 1'b0, word_trunc};
                burst.push_back(r);
                line_pos = line_pos + gww_pkg::LL_W'(word_fill) + gww_pkg::LL_W'(1);
                word_fill = 0;
                word_trunc = 1'b0;
            end
            if (b == gww_pkg::CH_END) begin
                r = '{gww_pkg::CH_NL, 1'b0, 1'b1, 1'b0};
                burst.push_back(r);
                line_pos = '0;
            end
            if (burst.size() != 0) begin
                burst[burst.size()-1].last = 1'b1;
            end
            foreach (burst[k]) begin
                wrap_out_q.push_back(burst[k]);
            end
        end else if (word_fill < STORE_DEPTH) begin
            word_buf[word_fill] = b;
            word_fill++;
        end else begin
            word_trunc = 1'b1;
        end
    endtask

    always @(negedge i_clk) begin
        pop <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge i_clk) begin
        t_wrap_out want;
        if (i_rst_n && pop && !empty) begin
            if (wrap_out_q.size() == 0) begin
                report_mismatch("unexpected result, byte", int'(o_out_byte), -1);
            end else begin
                want = wrap_out_q.pop_front();
                if (o_out_byte !== want.ch) begin
                    report_mismatch("out_byte", int'(o_out_byte), int'(want.ch));
                end
                if (o_run_last !== want.last) begin
                    report_mismatch("run_last", int'(o_run_last), int'(want.last));
                end
                if (o_text_done !== want.done) begin
                    report_mismatch("text_done", int'(o_text_done), int'(want.done));
                end
                if (o_word_cut !== want.cut) begin
                    report_mismatch("word_cut", int'(o_word_cut), int'(want.cut));
                end
            end
        end
    end

    // Called and left at a falling edge; push stays high for a following byte.
    task automatic send_byte(input logic [gww_pkg::BYTE_W-1:0] b);
        int gap;
        if ($urandom_range(99) < send_idle_pct) begin
            gap = $urandom_range(1, 4);
            push <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        push <= 1'b1;
        i_in_byte <= b;
        do @(posedge i_clk); while (full);
        predict_byte(b);
        @(negedge i_clk);
    endtask

    task automatic send_string(input string s);
        for (int k = 0; k < s.len(); k++) begin
            send_byte(s[k]);
        end
    endtask

    task automatic wait_drain();
        push <= 1'b0;
        do @(negedge i_clk); while (wrap_out_q.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_width(input logic [gww_pkg::CFG_W-1:0] w);
        wait_drain();
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= w;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        wrap_width = w;
    endtask

    function automatic logic [gww_pkg::BYTE_W-1:0] random_word_char();
        logic [gww_pkg::BYTE_W-1:0] c;
        do c = gww_pkg::BYTE_W'($urandom_range(1, 255)); while (c == gww_pkg::CH_SPACE);
        return c;
    endfunction

    // Runs at the reset width: bare end, repeated spaces, extreme byte values.
    task automatic test_spaces_and_end();
        send_byte(gww_pkg::CH_END);
        send_string("  ");
        send_byte(8'h01);
        send_byte(8'hFF);
        send_string("  ");
        send_byte(gww_pkg::CH_NL);
        send_byte(8'h7F);
        send_byte(gww_pkg::CH_END);
    endtask

    // A first word wider than the line gets a blank line, later words wrap.
    task automatic test_narrow_width();
        write_width(8'd3);
        send_string("abcd ab abcde c");
        send_byte(gww_pkg::CH_END);
    endtask

    task automatic test_zero_width();
        write_width(8'd0);
        send_string("x y");
        send_byte(gww_pkg::CH_END);
    endtask

    task automatic test_cut_word();
        write_width(8'd255);
        repeat (STORE_DEPTH + 2) send_byte(8'h77);
        send_string(" ok");
        send_byte(gww_pkg::CH_END);
    endtask

    task automatic test_random_text(input int s_pct, input int r_pct,
                                    input logic [gww_pkg::CFG_W-1:0] w,
                                    input int n_items);
        int sent;
        int len;
        int r;
        write_width(w);
        send_idle_pct = s_pct;
        recv_stall_pct = r_pct;
        sent = 0;
        while (sent < n_items) begin
            r = $urandom_range(99);
            if (r < 8) begin
                len = $urandom_range(STORE_DEPTH + 1, STORE_DEPTH + 8);
            end else if (r < 15) begin
                len = 0;
            end else begin
                len = $urandom_range(1, 12);
            end
            repeat (len) send_byte(random_word_char());
            r = $urandom_range(99);
            if (r < 6) begin
                send_byte(gww_pkg::CH_END);
            end else if (r < 12) begin
                send_string("  ");
            end else begin
                send_byte(gww_pkg::CH_SPACE);
            end
            sent += len + 1;
            if ($urandom_range(99) < 4) begin
                push <= 1'b0;
                do @(negedge i_clk); while (wrap_out_q.size() != 0);
            end
        end
        send_byte(gww_pkg::CH_END);
    endtask

    initial begin
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        send_idle_pct = 23;
        recv_stall_pct = 66;
        test_spaces_and_end();
        test_narrow_width();
        test_zero_width();
        test_cut_word();
        test_random_text(23, 66, 8'd1, 60);
        test_random_text(23, 66, 8'd255, 60);
        test_random_text(66, 23, gww_pkg::CFG_W'($urandom_range(8, 40)), 60);
        test_random_text(66, 23, 8'd0, 60);
        test_random_text(0, 0, gww_pkg::CFG_W'($urandom_range(1, 255)), 60);
        test_random_text(0, 0, 8'd12, 60);
        wait_drain();
        if (mismatch_count == 0) begin
            $display("** greedy_word_wrap: PASSED **");
        end else begin
            $display("** greedy_word_wrap: FAILED **");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/gww_pkg.sv
hdl/gww_ram.sv
hdl/gww_cmd_fifo.sv
hdl/gww_front.sv
hdl/gww_back.sv
hdl/greedy_word_wrap.sv
tb/greedy_word_wrap_tb.sv
